// ===== src/cflp_pkg.sv =====
// ----------------------------------------------------------------------------
// cflp_pkg
// Shared constants, types and codes for the comma field line parser.
// ----------------------------------------------------------------------------
package cflp_pkg;

    // Field and result geometry
    localparam int VAL_W        = 21;
    localparam int NUM_FIELDS   = 3;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_FIELDS_W = NUM_FIELDS * VAL_W + NUM_FIELDS;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Line limits
    localparam int LINE_BYTES_DEF = 64;
    localparam int CHAR_CNT_W     = 3;
    localparam int COMMA_CNT_W    = 3;
    localparam logic [CHAR_CNT_W-1:0] FIELD_CHARS = CHAR_CNT_W'(6);

    // Character codes
    localparam logic [7:0] CH_HDR   = 8'h01;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Comma counts that bound the decoded fields
    localparam logic [COMMA_CNT_W-1:0] COMMA_FIRST = COMMA_CNT_W'(1);
    localparam logic [COMMA_CNT_W-1:0] COMMA_LAST  = COMMA_CNT_W'(3);
    localparam logic [COMMA_CNT_W-1:0] COMMA_SAT   = COMMA_CNT_W'(4);

    // Number conversion state
    typedef enum logic [3:0] {
        NUM_SIGN = 4'b0001,
        NUM_POS  = 4'b0010,
        NUM_NEG  = 4'b0100,
        NUM_STOP = 4'b1000
    } t_num_state;

    typedef struct packed {
        t_num_state              st;
        logic signed [VAL_W-1:0] acc;
    } t_num;

    // One line result toward the output register
    typedef struct packed {
        logic                                valid;
        logic [NUM_FIELDS-1:0]               mask;
        logic [NUM_FIELDS-1:0][VAL_W-1:0]    values;
    } t_result;

endpackage

// ===== src/cflp_num_step.sv =====
// ----------------------------------------------------------------------------
// cflp_num_step
// One character step of the decimal field conversion (blanks, sign, digits).
// ----------------------------------------------------------------------------
module cflp_num_step (
    input  cflp_pkg::t_num   i_cur,
    input  logic [7:0]       i_char,
    output cflp_pkg::t_num   o_nxt
);
    import cflp_pkg::*;

    logic                    digit;
    logic                    blank;
    logic signed [VAL_W-1:0] dval;
    logic signed [VAL_W-1:0] times10;

    // Classify the character
    assign digit   = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign blank   = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
    assign dval    = VAL_W'(i_char[3:0]);
    assign times10 = (i_cur.acc <<< 3) + (i_cur.acc <<< 1);

    // Advance the conversion
    always_comb begin
        o_nxt = i_cur;
        unique case (i_cur.st)
            NUM_SIGN: begin
                priority if (blank) begin
                    o_nxt.st = NUM_SIGN;
                end else if (i_char == CH_PLUS) begin
                    o_nxt.st = NUM_POS;
                end else if (i_char == CH_MINUS) begin
                    o_nxt.st = NUM_NEG;
                end else if (digit) begin
                    o_nxt.st  = NUM_POS;
                    o_nxt.acc = dval;
                end else begin
                    o_nxt.st = NUM_STOP;
                end
            end
            NUM_POS: begin
                if (digit) begin
                    o_nxt.acc = times10 + dval;
                end else begin
                    o_nxt.st = NUM_STOP;
                end
            end
            NUM_NEG: begin
                if (digit) begin
                    o_nxt.acc = times10 - dval;
                end else begin
                    o_nxt.st = NUM_STOP;
                end
            end
            NUM_STOP: begin
                o_nxt = i_cur;
            end
            default: begin
                o_nxt.st = NUM_STOP;
            end
        endcase
    end

endmodule

// ===== src/cflp_line_ctrl.sv =====
// ----------------------------------------------------------------------------
// cflp_line_ctrl
// Line framing state, field decoding, pending fields and retained values.
// ----------------------------------------------------------------------------
module cflp_line_ctrl #(
    parameter int LINE_BYTES = cflp_pkg::LINE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    output cflp_pkg::t_result o_res
);
    import cflp_pkg::*;

    localparam int CNT_W = $clog2(LINE_BYTES + 1);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LINE_BYTES);

    logic                          r_cr_seen,  n_cr_seen;
    logic [CNT_W-1:0]              r_byte_cnt, n_byte_cnt;
    logic                          r_header,   n_header;
    logic [COMMA_CNT_W-1:0]        r_comma,    n_comma;
    logic [CHAR_CNT_W-1:0]         r_char,     n_char;
    t_num                          r_num,      n_num;
    logic [NUM_FIELDS-1:0]         r_pmask,    n_pmask;
    logic [NUM_FIELDS-1:0][VAL_W-1:0] r_pend,  n_pend;
    logic [NUM_FIELDS-1:0][VAL_W-1:0] r_kept,  n_kept;

    t_num                          step_num;
    t_num                          num_reset;
    logic                          in_field;
    logic [1:0]                    pend_idx;
    logic [CNT_W-1:0]              cnt_inc;

    assign num_reset = '{st: NUM_SIGN, acc: '0};
    assign in_field  = (r_comma >= COMMA_FIRST) && (r_comma <= COMMA_LAST);
    assign pend_idx  = 2'(r_comma - COMMA_FIRST);
    assign cnt_inc   = r_byte_cnt + CNT_W'(1);

    cflp_num_step u_num_step (
        .i_cur  (r_num),
        .i_char (i_byte),
        .o_nxt  (step_num)
    );

    // Next line state for the byte at hand
    always_comb begin
        n_cr_seen  = r_cr_seen;
        n_byte_cnt = r_byte_cnt;
        n_header   = r_header;
        n_comma    = r_comma;
        n_char     = r_char;
        n_num      = r_num;
        n_pmask    = r_pmask;
        n_pend     = r_pend;
        n_kept     = r_kept;
        o_res      = '0;
        o_res.values = r_kept;

        priority if (i_byte == CH_HDR) begin
            // restart the line with the header stored
            n_cr_seen  = 1'b0;
            n_byte_cnt = CNT_W'(1);
            n_header   = 1'b1;
            n_comma    = '0;
            n_pmask    = '0;
            n_char     = '0;
            n_num      = num_reset;
        end else if (r_cr_seen) begin
            // LF after CR closes a headed line, anything else drops it
            if ((i_byte == CH_LF) && r_header) begin
                for (int i = 0; i < NUM_FIELDS; i++) begin
                    if (r_pmask[i]) begin
                        n_kept[i] = r_pend[i];
                    end
                end
                o_res.valid  = 1'b1;
                o_res.mask   = r_pmask;
                o_res.values = n_kept;
            end
            n_cr_seen  = 1'b0;
            n_byte_cnt = '0;
            n_header   = 1'b0;
            n_comma    = '0;
            n_pmask    = '0;
            n_char     = '0;
            n_num      = num_reset;
        end else if (i_byte == CH_CR) begin
            n_cr_seen = 1'b1;
        end else begin
            // decode field text
            if (r_header) begin
                if (i_byte == CH_COMMA) begin
                    if (in_field) begin
                        for (int i = 0; i < NUM_FIELDS; i++) begin
                            if (pend_idx == 2'(i)) begin
                                n_pend[i]  = r_num.acc;
                                n_pmask[i] = 1'b1;
                            end
                        end
                    end
                    if (r_comma < COMMA_SAT) begin
                        n_comma = r_comma + COMMA_CNT_W'(1);
                    end
                    n_char = '0;
                    n_num  = num_reset;
                end else if (in_field && (r_char < FIELD_CHARS)) begin
                    n_char = r_char + CHAR_CNT_W'(1);
                    n_num  = step_num;
                end
            end
            // drop the line once it reaches the byte limit
            if (cnt_inc >= LIMIT) begin
                n_cr_seen  = 1'b0;
                n_byte_cnt = '0;
                n_header   = 1'b0;
                n_comma    = '0;
                n_pmask    = '0;
                n_char     = '0;
                n_num      = num_reset;
            end else begin
                n_byte_cnt = cnt_inc;
            end
        end
    end

    // Control state and retained values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr_seen  <= 1'b0;
            r_byte_cnt <= '0;
            r_header   <= 1'b0;
            r_comma    <= '0;
            r_char     <= '0;
            r_num      <= num_reset;
            r_pmask    <= '0;
            r_kept     <= '0;
        end else if (i_en) begin
            r_cr_seen  <= n_cr_seen;
            r_byte_cnt <= n_byte_cnt;
            r_header   <= n_header;
            r_comma    <= n_comma;
            r_char     <= n_char;
            r_num      <= n_num;
            r_pmask    <= n_pmask;
            r_kept     <= n_kept;
        end
    end

    // Pending field values, read only under their mask bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pend <= n_pend;
        end
    end

endmodule

// ===== src/comma_field_line_parser.sv =====
// ----------------------------------------------------------------------------
// comma_field_line_parser
// Byte stream line parser that decodes three comma separated decimal fields.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on the s_axis channel, one byte per request. A 0x01
//   byte starts a line; CR LF ends it. A line that began with 0x01 yields one
//   request on m_axis carrying the retained distance, output and stop values
//   and a mask of the fields this line updated. Other lines, lines broken by
//   a bad byte after CR, and lines that reach LINE_BYTES yield nothing.
//   Throughput: one byte per cycle, sustained while m_axis does not stall, as
//   the line state is updated combinationally between the input and result registers.
//   Path: the closing LF is held in the input register, and its result is
//   then captured in the result register, which drives m_axis.
//   Reset: i_rst_n low at a clock edge clears the line state, the retained
//   values (to zero) and both register stages.
//   Stall: while a result waits on m_axis with m_axis_tready low, no byte
//   advances; the next byte waits in the input register and s_axis_tready
//   falls until the result is taken.
// ----------------------------------------------------------------------------
module comma_field_line_parser #(
    parameter int LINE_BYTES = cflp_pkg::LINE_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] rx_byte
    input  logic [cflp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [20:0] distance, [41:21] output_value, [62:42] stop_value,
    // [65:63] updated_mask, [71:66] zero
    output logic [cflp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import cflp_pkg::*;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   out_free;
    logic                   consume;
    t_result                res;

    // The held byte advances whenever the result register can take a result
    assign out_free      = !r_out_valid || m_axis_tready;
    assign consume       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    cflp_line_ctrl #(
        .LINE_BYTES (LINE_BYTES)
    ) u_line_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (consume),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && res.valid) begin
            r_out_data <= OUT_TDATA_W'({res.mask, res.values[2], res.values[1],
                                        res.values[0]});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A result comes only from a closing LF
    a_result_on_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && res.valid) |-> (r_in_byte == CH_LF))
        else $error("result produced by a byte other than LF");

    // Fields are committed in order, so the mask is always contiguous
    a_mask_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> (res.mask == 3'b000 || res.mask == 3'b001 ||
                       res.mask == 3'b011 || res.mask == 3'b111))
        else $error("updated mask not contiguous");

    // Input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without a held result");

endmodule
